@@ src/ecs_pkg.sv @@
`timescale 1ns / 1ps

package ecs_pkg;

    localparam int VID_W      = 10;
    localparam int W_W        = 32;
    localparam int NUM_VERT   = 1024;
    localparam int EDGE_DEPTH = 4096;
    localparam int EADDR_W    = $clog2(EDGE_DEPTH);
    localparam int VADDR_W    = $clog2(NUM_VERT);
    localparam int CNT_W      = EADDR_W + 1;
    localparam int VCNT_W     = 11;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // sort modes
    localparam logic [MODE_W-1:0] MODE_SRC     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DST     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DST_SRC = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_READ  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_KEY_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

    // register indexes
    localparam logic REG_SORT_MODE = 1'b0;
    localparam logic REG_VCOUNT    = 1'b1;

    typedef struct packed {
        logic               op;
        logic [VID_W-1:0]   src;
        logic [VID_W-1:0]   dst;
        logic [W_W-1:0]     weight;
        logic               last;
        logic [EADDR_W-1:0] idx;
    } t_item;

    typedef struct packed {
        logic [VID_W-1:0]    src;
        logic [VID_W-1:0]    dst;
        logic [W_W-1:0]      weight;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    held;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_CLR,
        S_CNT_A,
        S_CNT_B,
        S_CNT_C,
        S_SCAN_A,
        S_SCAN_B,
        S_PERM_A,
        S_PERM_B,
        S_PERM_C,
        S_COPY_A,
        S_COPY_B,
        S_RESP
    } t_state;

endpackage

@@ src/ecs_engine.sv @@
`timescale 1ns / 1ps

module ecs_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  ecs_pkg::t_item              i_item,
    input  logic [ecs_pkg::MODE_W-1:0]  i_mode,
    input  logic [ecs_pkg::VCNT_W-1:0]  i_vmax,
    output logic                        o_ready,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output ecs_pkg::t_result            o_res
);
    import ecs_pkg::*;

    t_state  r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_sorted_valid, n_sorted_valid;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [CNT_W-1:0]   r_base, n_base;
    logic [VID_W-1:0]   r_key, n_key;
    logic               r_pass_dst, n_pass_dst;
    logic               r_second, n_second;
    t_result            r_res, n_res;

    // edge and bucket stores
    logic [VID_W-1:0] in_src_mem [EDGE_DEPTH];
    logic [VID_W-1:0] in_dst_mem [EDGE_DEPTH];
    logic [W_W-1:0]   in_w_mem   [EDGE_DEPTH];
    logic [VID_W-1:0] so_src_mem [EDGE_DEPTH];
    logic [VID_W-1:0] so_dst_mem [EDGE_DEPTH];
    logic [W_W-1:0]   so_w_mem   [EDGE_DEPTH];
    logic [CNT_W-1:0] bk_mem     [NUM_VERT];

    logic [VID_W-1:0] in_src_q, in_dst_q, so_src_q, so_dst_q;
    logic [W_W-1:0]   in_w_q, so_w_q;
    logic [CNT_W-1:0] bk_q;

    logic               in_we, in_re, so_we, so_re, bk_we, bk_re;
    logic [EADDR_W-1:0] in_waddr, in_raddr, so_waddr, so_raddr;
    logic [VID_W-1:0]   in_wsrc, in_wdst;
    logic [W_W-1:0]     in_ww;
    logic [VADDR_W-1:0] bk_waddr, bk_raddr;
    logic [CNT_W-1:0]   bk_wdata;

    logic [CNT_W-1:0] load_cnt;
    logic [VID_W-1:0] key;
    logic             vert_last;

    assign load_cnt  = r_sorted_valid ? '0 : r_count;
    assign key       = r_pass_dst ? in_dst_q : in_src_q;
    assign vert_last = (r_i[VADDR_W-1:0] == VADDR_W'(NUM_VERT - 1));

    always_ff @(posedge i_clk) begin
        if (in_we) begin
            in_src_mem[in_waddr] <= in_wsrc;
            in_dst_mem[in_waddr] <= in_wdst;
            in_w_mem[in_waddr]   <= in_ww;
        end
        if (in_re) begin
            in_src_q <= in_src_mem[in_raddr];
            in_dst_q <= in_dst_mem[in_raddr];
            in_w_q   <= in_w_mem[in_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (so_we) begin
            so_src_mem[so_waddr] <= in_src_q;
            so_dst_mem[so_waddr] <= in_dst_q;
            so_w_mem[so_waddr]   <= in_w_q;
        end
        if (so_re) begin
            so_src_q <= so_src_mem[so_raddr];
            so_dst_q <= so_dst_mem[so_raddr];
            so_w_q   <= so_w_mem[so_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (bk_we) begin
            bk_mem[bk_waddr] <= bk_wdata;
        end
        if (bk_re) begin
            bk_q <= bk_mem[bk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_sorted_valid <= 1'b0;
            r_i            <= '0;
            r_base         <= '0;
            r_pass_dst     <= 1'b0;
            r_second       <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_sorted_valid <= n_sorted_valid;
            r_i            <= n_i;
            r_base         <= n_base;
            r_pass_dst     <= n_pass_dst;
            r_second       <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_res <= n_res;
    end

    // next state
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_sorted_valid = r_sorted_valid;
        n_i            = r_i;
        n_base         = r_base;
        n_key          = r_key;
        n_pass_dst     = r_pass_dst;
        n_second       = r_second;
        n_res          = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_res = '0;
                    if (i_item.op == OP_LOAD) begin
                        n_sorted_valid = 1'b0;
                        n_count        = load_cnt;
                        if (load_cnt == CNT_W'(EDGE_DEPTH)) begin
                            n_res.status = ST_OVERFLOW;
                        end else if ({1'b0, i_item.src} >= i_vmax ||
                                     {1'b0, i_item.dst} >= i_vmax) begin
                            n_res.status = ST_KEY_RANGE;
                        end else begin
                            n_res.status = ST_OK;
                            n_count      = load_cnt + 1'b1;
                        end
                        n_res.held = n_count;
                        if (i_item.last) begin
                            n_i        = '0;
                            n_base     = '0;
                            n_pass_dst = (i_mode == MODE_DST) || (i_mode == MODE_DST_SRC);
                            n_second   = (i_mode == MODE_DST_SRC);
                            n_state    = S_CLR;
                        end else begin
                            n_state = S_RESP;
                        end
                    end else begin
                        n_res.held = r_count;
                        if (!r_sorted_valid || {1'b0, i_item.idx} >= r_count) begin
                            n_res.status = ST_BAD_READ;
                            n_state      = S_RESP;
                        end else begin
                            n_res.status = ST_OK;
                            n_state      = S_RD_WAIT;
                        end
                    end
                end
            end
            S_RD_WAIT: begin
                n_res.src    = so_src_q;
                n_res.dst    = so_dst_q;
                n_res.weight = so_w_q;
                n_state      = S_RESP;
            end
            S_CLR: begin
                if (vert_last) begin
                    n_i     = '0;
                    n_state = S_CNT_A;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_CNT_A: begin
                if (r_i == r_count) begin
                    n_i     = '0;
                    n_state = S_SCAN_A;
                end else begin
                    n_state = S_CNT_B;
                end
            end
            S_CNT_B: begin
                n_key   = key;
                n_state = S_CNT_C;
            end
            S_CNT_C: begin
                n_i     = r_i + 1'b1;
                n_state = S_CNT_A;
            end
            S_SCAN_A: n_state = S_SCAN_B;
            S_SCAN_B: begin
                n_base = r_base + bk_q;
                if (vert_last) begin
                    n_i     = '0;
                    n_state = S_PERM_A;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SCAN_A;
                end
            end
            S_PERM_A: begin
                if (r_i == r_count) begin
                    n_i = '0;
                    if (r_second) begin
                        n_state = S_COPY_A;
                    end else begin
                        n_sorted_valid = 1'b1;
                        n_state        = S_RESP;
                    end
                end else begin
                    n_state = S_PERM_B;
                end
            end
            S_PERM_B: begin
                n_key   = key;
                n_state = S_PERM_C;
            end
            S_PERM_C: begin
                n_i     = r_i + 1'b1;
                n_state = S_PERM_A;
            end
            S_COPY_A: begin
                if (r_i == r_count) begin
                    n_i        = '0;
                    n_base     = '0;
                    n_pass_dst = 1'b0;
                    n_second   = 1'b0;
                    n_state    = S_CLR;
                end else begin
                    n_state = S_COPY_B;
                end
            end
            S_COPY_B: begin
                n_i     = r_i + 1'b1;
                n_state = S_COPY_A;
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls and outputs
    always_comb begin
        in_we    = 1'b0;
        in_waddr = load_cnt[EADDR_W-1:0];
        in_wsrc  = i_item.src;
        in_wdst  = i_item.dst;
        in_ww    = i_item.weight;
        in_re    = 1'b0;
        in_raddr = r_i[EADDR_W-1:0];
        so_we    = 1'b0;
        so_waddr = bk_q[EADDR_W-1:0];
        so_re    = 1'b0;
        so_raddr = r_i[EADDR_W-1:0];
        bk_we    = 1'b0;
        bk_waddr = r_key;
        bk_wdata = bk_q + 1'b1;
        bk_re    = 1'b0;
        bk_raddr = key;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_item.op == OP_LOAD) begin
                    in_we = (load_cnt != CNT_W'(EDGE_DEPTH)) &&
                            ({1'b0, i_item.src} < i_vmax) &&
                            ({1'b0, i_item.dst} < i_vmax);
                end
                if (i_start && i_item.op == OP_READ) begin
                    so_re    = 1'b1;
                    so_raddr = i_item.idx;
                end
            end
            S_CLR: begin
                bk_we    = 1'b1;
                bk_waddr = r_i[VADDR_W-1:0];
                bk_wdata = '0;
            end
            S_CNT_A, S_PERM_A: in_re = (r_i != r_count);
            S_CNT_B, S_PERM_B: bk_re = 1'b1;
            S_CNT_C: bk_we = 1'b1;
            S_SCAN_A: begin
                bk_re    = 1'b1;
                bk_raddr = r_i[VADDR_W-1:0];
            end
            S_SCAN_B: begin
                bk_we    = 1'b1;
                bk_waddr = r_i[VADDR_W-1:0];
                bk_wdata = r_base;
            end
            S_PERM_C: begin
                bk_we = 1'b1;
                so_we = 1'b1;
            end
            S_COPY_A: so_re = (r_i != r_count);
            S_COPY_B: begin
                in_we    = 1'b1;
                in_waddr = r_i[EADDR_W-1:0];
                in_wsrc  = so_src_q;
                in_wdst  = so_dst_q;
                in_ww    = so_w_q;
            end
            default: ;
        endcase
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = r_res;

endmodule

@@ src/edge_counting_sort.sv @@
`timescale 1ns / 1ps

// channel   | dir | handshake               | contents
// s_axis    | in  | s_axis_tvalid / tready  | one load or read transaction
// m_axis    | out | m_axis_tvalid / tready  | one result transaction per input
// cfg       | in  | i_cfg_we                | sort_mode, vertex_count_in_use
//
// the last edge of a set runs the sort, a counting sort of the held edges through
// the bucket memory: clear every bucket, count each edge, scan each vertex into
// a base offset, then permute each edge into the sorted store
// destination-then-source mode adds a copy back to the input store and a second pass
// synchronous active-low reset clears control state only, no clearing pass
// s_axis_tready is low while a transaction is in work; a waiting result sits
// in the output register so the next transaction can already be taken

module edge_counting_sort (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // src[9:0], dst[19:10], edge_weight[51:20], read_index[63:52]
    input  logic [ecs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tlast,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // out_src[9:0], out_dst[19:10], out_weight[51:20], status[53:52],
    // edges_held[66:54], zero fill[71:67]
    output logic [ecs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [ecs_pkg::VCNT_W-1:0]     i_cfg_wdata
);
    import ecs_pkg::*;

    logic [MODE_W-1:0] r_sort_mode;
    logic [VCNT_W-1:0] r_vcount;
    logic [VCNT_W-1:0] vmax;

    t_item   item;
    t_result eng_res;
    logic    eng_ready, eng_res_valid, res_ready;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_mode <= MODE_SRC;
            r_vcount    <= VCNT_W'(NUM_VERT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SORT_MODE: r_sort_mode <= i_cfg_wdata[MODE_W-1:0];
                REG_VCOUNT:    r_vcount    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // vertex count saturates at the bucket memory depth
    assign vmax = (r_vcount > VCNT_W'(NUM_VERT)) ? VCNT_W'(NUM_VERT) : r_vcount;

    // unpack the input transaction
    assign item.op     = s_axis_tuser;
    assign item.src    = s_axis_tdata[9:0];
    assign item.dst    = s_axis_tdata[19:10];
    assign item.weight = s_axis_tdata[51:20];
    assign item.last   = s_axis_tlast;
    assign item.idx    = s_axis_tdata[63:52];

    assign s_axis_tready = eng_ready;

    ecs_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_axis_tvalid && eng_ready),
        .i_item      (item),
        .i_mode      (r_sort_mode),
        .i_vmax      (vmax),
        .o_ready     (eng_ready),
        .o_res_valid (eng_res_valid),
        .i_res_ready (res_ready),
        .o_res       (eng_res)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= eng_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && eng_res_valid) begin
            r_m_data <= {5'b0, eng_res.held, eng_res.status, eng_res.weight,
                         eng_res.dst, eng_res.src};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // one transaction in work at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while previous transaction in work");

    // a finished result always lands in the output register
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_res_valid && res_ready |=> m_axis_tvalid)
        else $error("result lost between engine and output register");

    // a failed read carries no edge
    a_bad_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[53:52] == ST_BAD_READ |->
            m_axis_tdata[51:0] == '0)
        else $error("failed read returned edge data");

endmodule
